### hw/rtl/wba_pkg.sv
// ----------------------------------------------------------------------------
// Weighted bin averager package
// Shared types and constants for the bin averager and its divider.
// ----------------------------------------------------------------------------
package wba_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] CFG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] CFG_BINS       = 2'd2;

  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [55:0] VSUM_MAX = 56'h7F_FFFF_FFFF_FFFF;
  localparam logic [55:0] VSUM_MIN = 56'h80_0000_0000_0000;
  localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

  // One bin of accumulators as held in the bin memory
  typedef struct packed {
    logic [63:0] wsum;   // unsigned Q32.32 weight sum
    logic [63:0] wvsum;  // signed Q32.32 weighted value sum
    logic [55:0] vsum;   // signed Q40.16 value sum
    logic [63:0] sqsum;  // unsigned Q32.32 square sum
    logic [23:0] cnt;    // sample count
  } bin_entry_t;

  // Request to the shared divider: floor((hi*2^64 + lo) / den)
  typedef struct packed {
    logic        start;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hw/rtl/wba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, then register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hw/rtl/wba_div.sv
// ----------------------------------------------------------------------------
// Bin averager divider
// Radix-2 restoring divider, 128 by 64 bits, one quotient bit a cycle,
// saturating when the quotient would not fit in 64 bits.
// ----------------------------------------------------------------------------
module wba_div
  import wba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output div_stat_t   stat_o,
  output logic [63:0] quot_o
);

  logic [63:0] rem_q, lo_q, den_q, quot_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;

  logic        carry;
  logic [63:0] shifted;
  logic        take;

  // One restoring step
  always_comb begin
    carry   = rem_q[63];
    shifted = {rem_q[62:0], lo_q[63]};
    take    = carry || (shifted >= den_q);
  end

  // Control: load, iterate, flag completion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (req_i.hi >= req_i.den) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= 7'd64;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.hi;
      lo_q   <= req_i.lo;
      den_q  <= req_i.den;
      quot_q <= (req_i.hi >= req_i.den) ? U64_MAX : '0;
    end else if (busy_q) begin
      rem_q  <= take ? (shifted - den_q) : shifted;
      lo_q   <= {lo_q[62:0], 1'b0};
      quot_q <= {quot_q[62:0], take};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

### hw/rtl/weighted_bin_averager.sv
// ----------------------------------------------------------------------------
// Weighted bin averager
// Sorts samples into equal-width bins held in one memory and, on the last
// sample of a set, reports mean and error of every non-empty bin.
// ----------------------------------------------------------------------------
// Throughput: one sample at a time; a sample is dropped, or binned with a
// bin division on the shared radix-2 divider unless its offset is negative,
// and may need a weight division when it has a weight. A set end adds up to
// four divisions and a 32-step square root per reported bin and a scan of
// each empty bin. Reset is asynchronous; all bins read as empty straight
// after.
module weighted_bin_averager
  import wba_pkg::*;
#(
  parameter int BIN_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  // Sample stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // sample_x, sample_y, sample_err
  input  logic [2:0]   s_axis_tuser,   // x_finite, y_finite, err_finite
  input  logic         s_axis_tlast,   // set_end
  // Bin result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // bin_number, bin_center, bin_mean,
                                       // bin_error, zero pad
  output logic         m_axis_tlast    // last_bin
);

  localparam int AW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
  localparam logic [6:0] DEPTH7 = 7'(BIN_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_PRE, S_MULW, S_DIVW, S_SQW, S_BDIV, S_BSET,
    S_W0, S_W1, S_W2, S_W3, S_W4, S_W5, S_SQ0, S_SQ1, S_RMW,
    S_EINIT, S_ESCAN, S_ECDIV, S_ECSET, S_EWM, S_EWR, S_EPM, S_EPA,
    S_EPV0, S_EPV1, S_EPV2, S_EOUT, S_EHOLD, S_CLEAR
  } state_e;

  state_e state_q, ret_q;

  // Configuration
  logic [31:0] lo_q, hi_q;
  logic [6:0]  bins_q;

  // Sample registers
  logic [31:0] x_q, y_q, e_q;
  logic        xf_q, yf_q, ef_q, last_q;
  logic        ws_q;
  logic [AW-1:0] bin_q;
  logic [63:0] w_q, ph_q, wy_q, ysq_q;

  // Emission registers
  logic [6:0]  b_q;
  bin_entry_t  ent_q;
  logic [31:0] centre_q, mean_q, err_q;
  logic [63:0] m2_q;

  logic [BIN_DEPTH-1:0] valid_q;

  // Shared multiplier
  logic [31:0] op_a_q, op_b_q;
  logic [63:0] prod_q;

  // Divider
  div_req_t    div_req_q;
  div_stat_t   div_stat;
  logic [63:0] quot;

  // Square root unit
  logic        sq_start_q;
  logic [63:0] sq_arg_q, sq_x_q;
  logic [33:0] sq_rem_q;
  logic [31:0] sq_root_q;
  logic [5:0]  sq_cnt_q;
  logic        sq_busy_q, sq_done_q;

  // Memory ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  bin_entry_t    ram_wdata, ram_rdata;

  // Output registers
  logic          m_valid_q, m_last_q;
  logic [103:0]  m_data_q;

  // --------------------------------------------------------------------------
  // Derived values
  logic [32:0] span_w, d_w;
  logic        span_pos, d_neg, has_w, keep;
  logic [6:0]  n_w, nm1;
  logic [31:0] ay;
  logic        more;
  logic [63:0] wmag, wy_mag, wy_sum;
  logic        wneg, vneg;
  logic [55:0] vmag;
  logic [31:0] am;
  logic [63:0] var_w;

  always_comb begin
    span_w   = {hi_q[31], hi_q} - {lo_q[31], lo_q};
    span_pos = !span_w[32] && (span_w != '0);
    d_w      = {x_q[31], x_q} - {lo_q[31], lo_q};
    d_neg    = d_w[32];
    n_w      = (bins_q > DEPTH7) ? DEPTH7 : bins_q;
    nm1      = n_w - 7'd1;
    has_w    = ef_q && (e_q != '0);
    keep     = xf_q && yf_q && span_pos && (n_w != '0);
    ay       = y_q[31] ? (32'd0 - y_q) : y_q;
    wneg     = ent_q.wvsum[63];
    wmag     = wneg ? (64'd0 - ent_q.wvsum) : ent_q.wvsum;
    vneg     = ent_q.vsum[55];
    vmag     = vneg ? (56'd0 - ent_q.vsum) : ent_q.vsum;
    am       = mean_q[31] ? (32'd0 - mean_q) : mean_q;
    var_w    = (quot > m2_q) ? (quot - m2_q) : '0;
    // w*y magnitude from high and low partial products
    wy_sum   = {ph_q[47:0], 16'd0} + {16'd0, prod_q[63:16]};
    if (ph_q[63:47] != '0 || wy_sum[63]) begin
      wy_mag = S64_MAX;
    end else begin
      wy_mag = wy_sum;
    end
    // Any non-empty bin above the current one still to report
    more = 1'b0;
    for (int j = 0; j < BIN_DEPTH; j++) begin
      more = more | (valid_q[j] && (7'(j) > b_q) && (7'(j) < n_w));
    end
  end

  function automatic logic [31:0] clamp_s32(input logic neg, input logic [63:0] mag);
    logic [31:0] r;
    if (neg) begin
      r = (mag > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end else begin
      r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Read-modify-write of one bin, empty entries read as zero
  bin_entry_t  cur;
  logic [56:0] vs_sum;
  logic [64:0] sq_sum, w_sum, wv_sum;

  always_comb begin
    cur    = valid_q[bin_q] ? ram_rdata : '0;
    vs_sum = {cur.vsum[55], cur.vsum} + {{25{y_q[31]}}, y_q};
    sq_sum = {1'b0, cur.sqsum} + {1'b0, ysq_q};
    w_sum  = {1'b0, cur.wsum} + {1'b0, w_q};
    wv_sum = {cur.wvsum[63], cur.wvsum} + {wy_q[63], wy_q};
    ram_wdata = cur;
    if (vs_sum[56] != vs_sum[55]) begin
      ram_wdata.vsum = vs_sum[56] ? VSUM_MIN : VSUM_MAX;
    end else begin
      ram_wdata.vsum = vs_sum[55:0];
    end
    ram_wdata.sqsum = sq_sum[64] ? U64_MAX : sq_sum[63:0];
    ram_wdata.cnt   = (cur.cnt == COUNT_MAX) ? cur.cnt : (cur.cnt + 24'd1);
    if (has_w) begin
      ram_wdata.wsum = w_sum[64] ? U64_MAX : w_sum[63:0];
      if (wv_sum[64] != wv_sum[63]) begin
        ram_wdata.wvsum = wv_sum[64] ? S64_MIN : S64_MAX;
      end else begin
        ram_wdata.wvsum = wv_sum[63:0];
      end
    end
  end

  assign ram_we    = (state_q == S_RMW);
  assign ram_waddr = bin_q;
  assign ram_re    = (state_q == S_SQ1) || (state_q == S_ESCAN);
  assign ram_raddr = (state_q == S_ESCAN) ? b_q[AW-1:0] : bin_q;

  wba_ram #(
    .WIDTH ($bits(bin_entry_t)),
    .DEPTH (BIN_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  // --------------------------------------------------------------------------
  // Multiplier, one registered 32x32 product
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(op_a_q) * 64'(op_b_q);
  end

  // Square root, two radicand bits a cycle
  logic [35:0] sq_rt, sq_trial;
  logic        sq_take;

  always_comb begin
    sq_rt    = {sq_rem_q, sq_x_q[63:62]};
    sq_trial = {2'b00, sq_root_q, 2'b01};
    sq_take  = (sq_rt >= sq_trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_done_q <= 1'b0;
      sq_cnt_q  <= '0;
    end else begin
      sq_done_q <= 1'b0;
      if (sq_start_q) begin
        sq_busy_q <= 1'b1;
        sq_cnt_q  <= 6'd32;
      end else if (sq_busy_q) begin
        sq_cnt_q <= sq_cnt_q - 6'd1;
        if (sq_cnt_q == 6'd1) begin
          sq_busy_q <= 1'b0;
          sq_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_start_q) begin
      sq_x_q    <= sq_arg_q;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (sq_busy_q) begin
      sq_x_q    <= {sq_x_q[61:0], 2'b00};
      sq_rem_q  <= sq_take ? 34'(sq_rt - sq_trial) : sq_rt[33:0];
      sq_root_q <= {sq_root_q[30:0], sq_take};
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer, configuration and output registers
  assign s_axis_tready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      ret_q           <= S_IDLE;
      lo_q            <= '0;
      hi_q            <= 32'h0001_0000;
      bins_q          <= 7'd64;
      ws_q            <= 1'b0;
      valid_q         <= '0;
      div_req_q.start <= 1'b0;
      sq_start_q      <= 1'b0;
      m_valid_q       <= 1'b0;
    end else begin
      div_req_q.start <= 1'b0;
      sq_start_q      <= 1'b0;

      // Configuration writes
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_RANGE_LOW:  lo_q   <= cfg_wdata_i;
          CFG_RANGE_HIGH: hi_q   <= cfg_wdata_i;
          CFG_BINS:       bins_q <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            x_q    <= s_axis_tdata[31:0];
            y_q    <= s_axis_tdata[63:32];
            e_q    <= s_axis_tdata[95:64];
            xf_q   <= s_axis_tuser[0];
            yf_q   <= s_axis_tuser[1];
            ef_q   <= s_axis_tuser[2];
            last_q <= s_axis_tlast;
            if (s_axis_tuser[2] && (s_axis_tdata[95:64] != '0)) begin
              ws_q <= 1'b1;
            end
            state_q <= S_PRE;
          end
        end
        // Decide whether the sample is binned and find its bin
        S_PRE: begin
          if (keep) begin
            if (d_neg) begin
              bin_q   <= '0;
              state_q <= S_W0;
            end else begin
              op_a_q  <= d_w[31:0];
              op_b_q  <= 32'(n_w);
              ret_q   <= S_BDIV;
              state_q <= S_MULW;
            end
          end else begin
            state_q <= last_q ? S_EINIT : S_IDLE;
          end
        end
        S_MULW: state_q <= ret_q;
        S_DIVW: begin
          if (div_stat.done) begin
            state_q <= ret_q;
          end
        end
        S_SQW: begin
          if (sq_done_q) begin
            err_q   <= sq_root_q;
            state_q <= ret_q;
          end
        end
        S_BDIV: begin
          div_req_q <= '{start: 1'b1, hi: '0, lo: prod_q, den: 64'(span_w[31:0])};
          ret_q     <= S_BSET;
          state_q   <= S_DIVW;
        end
        S_BSET: begin
          bin_q   <= (quot > 64'(nm1)) ? nm1[AW-1:0] : quot[AW-1:0];
          state_q <= S_W0;
        end
        // Inverse-variance weight
        S_W0: begin
          w_q  <= '0;
          wy_q <= '0;
          if (has_w) begin
            op_a_q  <= e_q;
            op_b_q  <= e_q;
            ret_q   <= S_W1;
            state_q <= S_MULW;
          end else begin
            state_q <= S_SQ0;
          end
        end
        S_W1: begin
          if (prod_q <= 64'd1) begin
            w_q     <= U64_MAX;
            state_q <= S_W3;
          end else begin
            div_req_q <= '{start: 1'b1, hi: 64'd1, lo: '0, den: prod_q};
            ret_q     <= S_W2;
            state_q   <= S_DIVW;
          end
        end
        S_W2: begin
          w_q     <= quot;
          state_q <= S_W3;
        end
        S_W3: begin
          op_a_q  <= w_q[63:32];
          op_b_q  <= ay;
          ret_q   <= S_W4;
          state_q <= S_MULW;
        end
        S_W4: begin
          ph_q    <= prod_q;
          op_a_q  <= w_q[31:0];
          op_b_q  <= ay;
          ret_q   <= S_W5;
          state_q <= S_MULW;
        end
        S_W5: begin
          wy_q    <= y_q[31] ? (64'd0 - wy_mag) : wy_mag;
          state_q <= S_SQ0;
        end
        S_SQ0: begin
          op_a_q  <= ay;
          op_b_q  <= ay;
          ret_q   <= S_SQ1;
          state_q <= S_MULW;
        end
        S_SQ1: begin
          ysq_q   <= prod_q;
          state_q <= S_RMW;
        end
        S_RMW: begin
          valid_q[bin_q] <= 1'b1;
          state_q        <= last_q ? S_EINIT : S_IDLE;
        end
        // Report non-empty bins in ascending order
        S_EINIT: begin
          b_q     <= '0;
          state_q <= (span_pos && (n_w != '0)) ? S_ESCAN : S_CLEAR;
        end
        S_ESCAN: begin
          if (b_q >= n_w) begin
            state_q <= S_CLEAR;
          end else if (!valid_q[b_q[AW-1:0]]) begin
            b_q <= b_q + 7'd1;
          end else begin
            op_a_q  <= 32'({b_q, 1'b1});
            op_b_q  <= span_w[31:0];
            ret_q   <= S_ECDIV;
            state_q <= S_MULW;
          end
        end
        S_ECDIV: begin
          ent_q     <= ram_rdata;
          div_req_q <= '{start: 1'b1, hi: '0, lo: prod_q, den: 64'({n_w, 1'b0})};
          ret_q     <= S_ECSET;
          state_q   <= S_DIVW;
        end
        S_ECSET: begin
          centre_q <= lo_q + quot[31:0];
          if (ws_q && (ent_q.wsum != '0)) begin
            div_req_q <= '{start: 1'b1, hi: 64'(wmag[63:48]),
                           lo: {wmag[47:0], 16'd0}, den: ent_q.wsum};
            ret_q     <= S_EWM;
          end else begin
            div_req_q <= '{start: 1'b1, hi: '0, lo: 64'(vmag), den: 64'(ent_q.cnt)};
            ret_q     <= S_EPM;
          end
          state_q <= S_DIVW;
        end
        S_EWM: begin
          mean_q <= clamp_s32(wneg, quot);
          if (ent_q.wsum <= 64'd1) begin
            sq_start_q <= 1'b1;
            sq_arg_q   <= U64_MAX;
            ret_q      <= S_EOUT;
            state_q    <= S_SQW;
          end else begin
            div_req_q <= '{start: 1'b1, hi: 64'd1, lo: '0, den: ent_q.wsum};
            ret_q     <= S_EWR;
            state_q   <= S_DIVW;
          end
        end
        S_EWR: begin
          sq_start_q <= 1'b1;
          sq_arg_q   <= quot;
          ret_q      <= S_EOUT;
          state_q    <= S_SQW;
        end
        S_EPM: begin
          mean_q <= clamp_s32(vneg, quot);
          if (ent_q.cnt > 24'd1) begin
            state_q <= S_EPA;
          end else begin
            err_q   <= '0;
            state_q <= S_EOUT;
          end
        end
        S_EPA: begin
          op_a_q  <= am;
          op_b_q  <= am;
          ret_q   <= S_EPV0;
          state_q <= S_MULW;
        end
        S_EPV0: begin
          m2_q      <= prod_q;
          div_req_q <= '{start: 1'b1, hi: '0, lo: ent_q.sqsum, den: 64'(ent_q.cnt)};
          ret_q     <= S_EPV1;
          state_q   <= S_DIVW;
        end
        S_EPV1: begin
          div_req_q <= '{start: 1'b1, hi: '0, lo: var_w, den: 64'(ent_q.cnt)};
          ret_q     <= S_EPV2;
          state_q   <= S_DIVW;
        end
        S_EPV2: begin
          sq_start_q <= 1'b1;
          sq_arg_q   <= quot;
          ret_q      <= S_EOUT;
          state_q    <= S_SQW;
        end
        S_EOUT: begin
          m_valid_q <= 1'b1;
          m_data_q  <= {2'b00, err_q, mean_q, centre_q, b_q[5:0]};
          m_last_q  <= !more;
          state_q   <= S_EHOLD;
        end
        // Hold the result until the transfer completes
        S_EHOLD: begin
          if (m_axis_tready) begin
            m_valid_q <= 1'b0;
            b_q       <= b_q + 7'd1;
            state_q   <= S_ESCAN;
          end
        end
        // Drop all bins and the weight flag
        S_CLEAR: begin
          valid_q <= '0;
          ws_q    <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  a_div_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_q.start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_bin_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RMW) |-> (7'(bin_q) < n_w))
    else $error("sample written outside the active bins");

endmodule

### dv/wba_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bin averager checker
// Watches the sample, result and configuration channels, keeps its own copy
// of the bin accumulators and compares every bin result field by field.
// ----------------------------------------------------------------------------
module wba_checker
  import wba_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  output int           fail_count_o,
  output int           pending_o,
  output int           results_seen_o
);

  typedef struct packed {
    logic [5:0]  num;
    logic [31:0] centre;
    logic [31:0] mean;
    logic [31:0] err;
    logic        last;
  } bin_result_t;

  bin_result_t result_q[$];

  logic [31:0] lo_reg, hi_reg;
  logic [6:0]  nbins_reg;
  logic [63:0] w_acc  [64];
  logic signed [63:0] wv_acc [64];
  logic signed [63:0] v_acc  [64];
  logic [63:0] sq_acc [64];
  logic [23:0] cnt_acc[64];
  logic        weighted_set;

  assign pending_o = result_q.size();

  // Wide quotient floor((hi*2^64 + lo) / d), saturated
  function automatic logic [63:0] wide_div(logic [63:0] hi, logic [63:0] lo, logic [63:0] d);
    logic [127:0] num;
    logic [127:0] q;
    num = {hi, lo};
    q = num / {64'd0, d};
    if (q[127:64] != 0) return U64_MAX;
    return q[63:0];
  endfunction

  function automatic logic [63:0] recip(logic [63:0] s);
    if (s <= 1) return U64_MAX;
    return wide_div(64'd1, 64'd0, s);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      bitv = r | (64'd1 << i);
      if ({64'd0, bitv} * {64'd0, bitv} <= {64'd0, x}) r = bitv;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp32(logic neg, logic [63:0] mag);
    if (neg) return (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  task automatic clear_accumulators();
    for (int b = 0; b < 64; b++) begin
      w_acc[b] = 0; wv_acc[b] = 0; v_acc[b] = 0; sq_acc[b] = 0; cnt_acc[b] = 0;
    end
    weighted_set = 0;
  endtask

  // Accumulate one sample and, on set end, queue the bin reports
  task automatic bin_sample(logic [95:0] d, logic [2:0] u, logic set_end);
    logic signed [63:0] x, y, lo, hi, span, off, v, centre;
    logic [63:0] e, q, ay, w, ph, pl, mag, m, er, msq, m2, vr, am;
    logic signed [63:0] sv;
    logic [6:0] n;
    logic [5:0] b;
    logic has_w;
    logic [31:0] mean;
    bin_result_t r;
    int idx;
    x = $signed(d[31:0]); y = $signed(d[63:32]); e = {32'd0, d[95:64]};
    lo = $signed(lo_reg); hi = $signed(hi_reg); span = hi - lo;
    n = (nbins_reg > 64) ? 7'd64 : nbins_reg;
    has_w = u[2] && e != 0;
    if (has_w) weighted_set = 1;
    if (u[0] && u[1] && span > 0 && n > 0) begin
      off = x - lo;
      q = (off < 0) ? 64'd0 : (64'(off) * n) / 64'(span);
      if (q > n - 1) q = n - 1;
      b = q[5:0];
      ay = (y < 0) ? 64'(-y) : 64'(y);
      v = v_acc[b] + y;
      v_acc[b] = (v > $signed({8'd0, VSUM_MAX})) ? $signed({8'd0, VSUM_MAX}) :
                 (v < $signed({8'hFF, VSUM_MIN})) ? $signed({8'hFF, VSUM_MIN}) : v;
      sq_acc[b] = (sq_acc[b] > U64_MAX - ay * ay) ? U64_MAX : sq_acc[b] + ay * ay;
      if (cnt_acc[b] < COUNT_MAX) cnt_acc[b]++;
      if (has_w) begin
        w = recip(e * e);
        ph = (w >> 32) * ay; pl = (w & 64'hFFFF_FFFF) * ay;
        w_acc[b] = (w_acc[b] > U64_MAX - w) ? U64_MAX : w_acc[b] + w;
        if (ph >= (64'd1 << 47)) mag = S64_MAX;
        else begin
          mag = (ph << 16) + (pl >> 16);
          if (mag > S64_MAX) mag = S64_MAX;
        end
        sv = (y < 0) ? -$signed(mag) : $signed(mag);
        v = wv_acc[b] + sv;
        if (sv > 0 && wv_acc[b] > 0 && v < 0) v = $signed(S64_MAX);
        else if (sv < 0 && wv_acc[b] < 0 && v >= 0) v = $signed(S64_MIN);
        wv_acc[b] = v;
      end
    end
    if (!set_end) return;
    if (span > 0 && n > 0) begin
      idx = -1;
      for (int i = 0; i < n; i++) begin
        if (cnt_acc[i] == 0) continue;
        centre = lo + 64'((64'(2 * i + 1) * 64'(span)) / (64'd2 * n));
        if (weighted_set && w_acc[i] > 0) begin
          sv = wv_acc[i];
          mag = (sv < 0) ? 64'(-sv) : 64'(sv);
          mean = clamp32(sv < 0, wide_div(mag >> 48, mag << 16, w_acc[i]));
          er = int_sqrt(recip(w_acc[i]));
        end else begin
          sv = v_acc[i];
          mag = (sv < 0) ? 64'(-sv) : 64'(sv);
          mean = clamp32(sv < 0, mag / cnt_acc[i]);
          if (cnt_acc[i] > 1) begin
            am = mean[31] ? 64'(-$signed(mean)) : {32'd0, mean};
            msq = sq_acc[i] / cnt_acc[i]; m2 = am * am;
            vr = (msq > m2) ? msq - m2 : 0;
            er = int_sqrt(vr / cnt_acc[i]);
          end else er = 0;
        end
        if (er > 64'hFFFF_FFFF) er = 64'hFFFF_FFFF;
        r.num = i[5:0]; r.centre = centre[31:0]; r.mean = mean; r.err = er[31:0];
        r.last = 0;
        result_q.push_back(r);
        idx = result_q.size() - 1;
      end
      if (idx >= 0) result_q[idx].last = 1;
    end
    clear_accumulators();
  endtask

  // Track configuration, samples and results at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    bin_result_t exp_r;
    if (!rst_ni) begin
      lo_reg <= 0; hi_reg <= 32'd65536; nbins_reg <= 7'd64;
      clear_accumulators();
      result_q.delete();
      fail_count_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_RANGE_LOW:  lo_reg <= cfg_wdata_i;
          CFG_RANGE_HIGH: hi_reg <= cfg_wdata_i;
          CFG_BINS:       nbins_reg <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) bin_sample(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen_o <= results_seen_o + 1;
        if (result_q.size() == 0) begin
          $error("unexpected bin result %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (m_axis_tdata[5:0] != exp_r.num ||
              m_axis_tdata[37:6] != exp_r.centre ||
              m_axis_tdata[69:38] != exp_r.mean ||
              m_axis_tdata[101:70] != exp_r.err ||
              m_axis_tlast != exp_r.last) begin
            if (m_axis_tdata[5:0] != exp_r.num)
              $error("bin_number exp %0d got %0d", exp_r.num, m_axis_tdata[5:0]);
            if (m_axis_tdata[37:6] != exp_r.centre)
              $error("bin_center exp %h got %h", exp_r.centre, m_axis_tdata[37:6]);
            if (m_axis_tdata[69:38] != exp_r.mean)
              $error("bin_mean exp %h got %h", exp_r.mean, m_axis_tdata[69:38]);
            if (m_axis_tdata[101:70] != exp_r.err)
              $error("bin_error exp %h got %h", exp_r.err, m_axis_tdata[101:70]);
            if (m_axis_tlast != exp_r.last)
              $error("last_bin exp %0d got %0d", exp_r.last, m_axis_tlast);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bin averager testbench
// Drives directed and random sample sets through several range and bin
// settings with random stalls on both streams; a checker predicts results.
// ----------------------------------------------------------------------------
module tb_top;
  import wba_pkg::*;

  logic         clk_i, rst_ni;
  logic         cfg_we_i;
  logic [1:0]   cfg_addr_i;
  logic [31:0]  cfg_wdata_i;
  logic         s_axis_tvalid, s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid, m_axis_tready;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;
  int           fail_count, pending, results_seen;
  int           sample_total, set_total;
  logic         calm;

  weighted_bin_averager dut (.*);

  wba_checker u_checker (
    .*,
    .fail_count_o(fail_count),
    .pending_o(pending),
    .results_seen_o(results_seen)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side stalls in bursts, none once calm
  initial begin
    int burst;
    m_axis_tready = 1;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 19);
        m_axis_tready <= 0;
        repeat (burst) @(posedge clk_i);
      end
      m_axis_tready <= 1;
    end
  end

  // Write one register; start on a fresh edge so the enable is set once per step
  task automatic write_cfg(logic [1:0] addr, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_addr_i <= addr; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // Wait for the checker to see the set end, for every result, then drain
  task automatic settle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // Offer one sample and hold it until transferred
  task automatic send_sample(logic [31:0] x, logic [31:0] y, logic [31:0] e,
                             logic [2:0] flags, logic set_end);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
    @(posedge clk_i);
    repeat (gap) @(posedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {e, y, x};
    s_axis_tuser <= flags;
    s_axis_tlast <= set_end;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    s_axis_tvalid <= 0;
    sample_total++;
    if (set_end) set_total++;
  endtask

  function automatic logic [31:0] pick_err();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return $urandom;
      3: return 32'hFFFF_FFFF;
      default: return $urandom_range(256, 200000);
    endcase
  endfunction

  // Random set of samples mostly inside the range, ending in set_end
  task automatic random_set(logic signed [31:0] lo, logic signed [31:0] hi, int len);
    logic [31:0] x, y;
    logic [2:0]  f;
    longint      span;
    span = longint'(hi) - longint'(lo);
    for (int k = 0; k < len; k++) begin
      if (span > 0 && $urandom_range(0, 7) != 0)
        x = 32'(longint'(lo) + longint'({$urandom, $urandom} % span));
      else x = $urandom;
      y = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 400000)) - 200000);
      f = ($urandom_range(0, 7) == 0) ? 3'($urandom) : {1'($urandom_range(0, 3) != 0), 2'b11};
      send_sample(x, y, pick_err(), f, k == len - 1);
    end
  endtask

  initial begin
    logic signed [31:0] lo, hi;
    int len;
    rst_ni = 0; calm = 0;
    cfg_we_i = 0; cfg_addr_i = CFG_RANGE_LOW; cfg_wdata_i = 0;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0; s_axis_tlast = 0;
    sample_total = 0; set_total = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset settings, field extremes, dropped and weightless samples
    send_sample(32'h0, 32'h7FFF_FFFF, 32'h1, 3'b111, 0);
    send_sample(32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 3'b111, 0);
    send_sample(32'h8000_0000, 32'h0001_0000, 32'h0, 3'b111, 0);
    send_sample(32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0001_0000, 3'b011, 0);
    send_sample(32'h0000_8000, 32'h1234_5678, 32'h0000_0100, 3'b110, 0);
    send_sample(32'h0000_8000, 32'h1234_5678, 32'h0000_0100, 3'b101, 0);
    send_sample(32'h0000_4000, 32'h0002_0000, 32'h0, 3'b011, 0);
    send_sample(32'h0000_4100, 32'h0003_0000, 32'h0, 3'b011, 1);
    settle();
    // Plain-mode set with a single sample bin
    send_sample(32'h0000_2000, 32'h0005_0000, 32'h0, 3'b011, 0);
    send_sample(32'h0000_2100, 32'hFFFB_0000, 32'h0, 3'b011, 0);
    send_sample(32'h0000_F000, 32'h0001_0000, 32'h0001_0000, 3'b011, 1);
    settle();
    // Empty range emits nothing but clears
    write_cfg(CFG_RANGE_LOW, 32'h0001_0000);
    write_cfg(CFG_RANGE_HIGH, 32'h0001_0000);
    send_sample(32'h0001_0000, 32'h0001_0000, 32'h1, 3'b111, 1);
    settle();
    // Zero bins, then too many bins, then one bin over the full range
    write_cfg(CFG_RANGE_LOW, 32'h0);
    write_cfg(CFG_RANGE_HIGH, 32'h0004_0000);
    write_cfg(CFG_BINS, 32'd0);
    send_sample(32'h0001_0000, 32'h0001_0000, 32'h0, 3'b011, 1);
    settle();
    write_cfg(CFG_BINS, 32'd127);
    send_sample(32'h0003_0000, 32'h0001_0000, 32'h0, 3'b011, 0);
    send_sample(32'hFFFF_0000, 32'h0002_0000, 32'h0, 3'b011, 1);
    settle();
    write_cfg(CFG_RANGE_LOW, 32'h8000_0000);
    write_cfg(CFG_RANGE_HIGH, 32'h7FFF_FFFF);
    write_cfg(CFG_BINS, 32'd1);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 3'b111, 0);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0002, 3'b111, 1);
    settle();

    // Random sets over several settings; sets hold one to twelve samples
    while (sample_total < 215) begin
      if (sample_total > 175) calm = 1;
      case ($urandom_range(0, 4))
        0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
        1: begin lo = $urandom; hi = $urandom; end
        2: begin lo = -32'sd65536; hi = 32'sd65536; end
        default: begin
          lo = 32'($signed($urandom_range(0, 200000)) - 100000);
          hi = lo + 32'($urandom_range(1, 500000));
        end
      endcase
      write_cfg(CFG_RANGE_LOW, lo);
      write_cfg(CFG_RANGE_HIGH, hi);
      write_cfg(CFG_BINS, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) :
                          $urandom_range(1, 8));
      len = $urandom_range(1, 12);
      random_set(lo, hi, len);
      settle();
    end

    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("Covered %0d samples in %0d sets, %0d bin results checked",
             sample_total, set_total, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS weighted_bin_averager");
    end else begin
      $display("FAIL weighted_bin_averager");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL weighted_bin_averager");
    $finish;
  end

endmodule
